// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a implies b on every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Check that a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ----- hdl/spd_pkg.sv -----
// Package: constants and state type of the shortest path unit
`timescale 1ns / 1ps
`default_nettype none
package spd_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 256;
  localparam int WeightBits  = 16;
  localparam int WeightFieldBits = 16;
  localparam int DistBits    = 22;
  localparam int CountBits   = 7;
  localparam int SrcBits     = 6;
  localparam logic [0:0] CfgVertexCount = 1'b0;
  localparam logic [0:0] CfgSourceVertex = 1'b1;
  localparam logic ActLoad = 1'b0;
  localparam logic ActRun  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_SETTLE,
    ST_EDGE,
    ST_TGT_RD,
    ST_TGT_WR,
    ST_EMIT_RD,
    ST_EMIT
  } spd_state_t;
endpackage
`default_nettype wire

// ----- hdl/shortest_path_distances_unit.sv -----
// Top level: single-source shortest path distances over a loaded edge list
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Load items (action 0) append an edge to an edge memory; edges past MAX_EDGES are
// dropped. A run item (action 1) clears the vertex memory, then, if the source vertex
// is below n, per round scans all n vertices for the least unsettled reached distance,
// marks that vertex settled and walks the E loaded edges (for each edge touching the
// settled vertex: read, then write-back of the neighbor distance). A scan that finds
// nothing ends the search and the n results follow in vertex order as out_tready
// allows. A run has at most n rounds; its length is set by the single-port vertex
// memory and the serial scan and edge walk; in_tready stays low until the last result
// is registered.
// in_tdata: edge_from[5:0], edge_to[11:6], edge_weight[27:12].
// out_tdata: vertex[5:0], distance[27:6], reachable[28].
module shortest_path_distances_unit #(
  parameter int MAX_VERTICES = spd_pkg::MaxVertices,
  parameter int MAX_EDGES    = spd_pkg::MaxEdges,
  parameter int WEIGHT_BITS  = spd_pkg::WeightBits
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // edge_from, edge_to, edge_weight
  input  wire logic        in_tuser,  // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata, // vertex, distance, reachable
  output logic             out_tlast, // last_result
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [6:0]  cfg_wdata
);
  import spd_pkg::*;
  localparam int VB = $clog2(MAX_VERTICES);
  localparam int EB = $clog2(MAX_EDGES) > 0 ? $clog2(MAX_EDGES) : 1;
  localparam int EC = $clog2(MAX_EDGES + 1);
  localparam int VC = $clog2(MAX_VERTICES + 1);
  localparam int CW = (VC > CountBits) ? VC : CountBits;
  localparam int WB = (WEIGHT_BITS < WeightFieldBits) ? WEIGHT_BITS : WeightFieldBits;
  localparam logic [DistBits-1:0] DistMax = '1;

  logic [CountBits-1:0] vcount_r;
  logic [SrcBits-1:0]   src_r;
  logic [EC-1:0]        ecount_r;
  spd_state_t state_r, state_nxt;

  // edge memory
  logic [2*SrcBits+WB-1:0] emem [MAX_EDGES];
  logic [2*SrcBits+WB-1:0] erd_r;
  logic [EB-1:0] eaddr;
  // vertex memory: {reached, settled, dist}
  logic [DistBits+1:0] vmem [MAX_VERTICES];
  logic [DistBits+1:0] vrd_r, vwd;
  logic [VB-1:0] vaddr;
  logic vwe;

  logic [VC-1:0] n;
  logic [VC-1:0] vi_r;     // vertex index counter
  logic [EC-1:0] ei_r, ei_nxt;  // edge index counter
  logic [VB-1:0] u_r, best_v_r, tgt_r;
  logic [DistBits-1:0] du_r, best_d_r;
  logic found_r;
  logic [DistBits:0] cand;
  logic [DistBits-1:0] cand_sat;
  logic [SrcBits-1:0] ea, eb;
  logic [WB-1:0] ew;
  logic hit_a, hit_b, any_hit;
  logic src_ok;
  logic out_full_r;
  logic out_load;
  logic [31:0] otd_r;
  logic otl_r;
  logic wdone;

  always_comb begin
    if (vcount_r == '0) n = VC'(1);
    else if (CW'(vcount_r) > CW'(MAX_VERTICES)) n = VC'(MAX_VERTICES);
    else n = VC'(vcount_r);
  end

  assign src_ok = (CW'(src_r) < CW'(n));
  assign ea = erd_r[SrcBits-1:0];
  assign eb = erd_r[2*SrcBits-1:SrcBits];
  assign ew = erd_r[2*SrcBits +: WB];
  assign hit_a = (CW'(u_r) == CW'(ea));
  assign hit_b = (CW'(u_r) == CW'(eb));
  assign any_hit = (CW'(ea) < CW'(n)) && (CW'(eb) < CW'(n)) && (hit_a || hit_b);
  assign cand = (DistBits+1)'(du_r) + (DistBits+1)'(ew);
  assign cand_sat = cand[DistBits] ? DistMax : cand[DistBits-1:0];
  assign wdone = (ei_r == ecount_r);

  assign in_tready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_EMIT) && (!out_full_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= CountBits'(64);
      src_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgVertexCount:  vcount_r <= cfg_wdata;
        CfgSourceVertex: src_r <= cfg_wdata[SrcBits-1:0];
        default: ;
      endcase
    end
  end

  // edge index: erd_r always holds the edge at ei_r
  always_comb begin
    ei_nxt = ei_r;
    unique case (state_r)
      ST_SCAN: if (vi_r == n) ei_nxt = '0;
      ST_EDGE: if (!wdone && !any_hit) ei_nxt = ei_r + EC'(1);
      ST_TGT_WR: ei_nxt = ei_r + EC'(1);
      default: ;
    endcase
  end

  // edge memory write and read
  always_comb eaddr = ei_nxt[EB-1:0];
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready && in_tuser == ActLoad && ecount_r < EC'(MAX_EDGES))
      emem[ecount_r[EB-1:0]] <= {in_tdata[2*SrcBits +: WB], in_tdata[2*SrcBits-1:0]};
    erd_r <= emem[eaddr];
  end

  // vertex memory address and write data
  always_comb begin
    vaddr = vi_r[VB-1:0];
    vwe = 1'b0;
    vwd = '0;
    unique case (state_r)
      ST_CLEAR: begin
        vwe = 1'b1;
        vwd = (CW'(src_r) == CW'(vi_r)) ? {1'b1, 1'b0, {DistBits{1'b0}}} : '0;
      end
      ST_SETTLE: begin
        vaddr = u_r;
        vwe = 1'b1;
        vwd = {1'b1, 1'b1, du_r};
      end
      ST_TGT_RD: vaddr = tgt_r;
      ST_TGT_WR: begin
        vaddr = tgt_r;
        // update only when the neighbor improves
        if (!vrd_r[DistBits+1] || cand_sat < vrd_r[DistBits-1:0]) begin
          vwe = 1'b1;
          vwd = {1'b1, vrd_r[DistBits], cand_sat};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwe) vmem[vaddr] <= vwd;
    vrd_r <= vmem[vaddr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid && in_tuser == ActRun) state_nxt = ST_CLEAR;
      ST_CLEAR: if (vi_r == n - VC'(1))
        state_nxt = src_ok ? ST_SCAN : ST_EMIT_RD;
      ST_SCAN: if (vi_r == n) state_nxt = (found_r || (vrd_r[DistBits+1]
        && !vrd_r[DistBits])) ? ST_SETTLE : ST_EMIT_RD;
      ST_SETTLE: state_nxt = ST_EDGE;
      ST_EDGE: begin
        if (wdone) state_nxt = ST_SCAN;
        else if (any_hit) state_nxt = ST_TGT_RD;
      end
      ST_TGT_RD: state_nxt = ST_TGT_WR;
      ST_TGT_WR: state_nxt = ST_EDGE;
      ST_EMIT_RD: state_nxt = ST_EMIT;
      ST_EMIT: if (!out_full_r || out_tready)
        state_nxt = (vi_r == n - VC'(1)) ? ST_IDLE : ST_EMIT_RD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ecount_r <= '0;
      vi_r <= '0;
      ei_r <= '0;
      found_r <= 1'b0;
      out_full_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ei_r <= ei_nxt;
      out_full_r <= out_load || (out_full_r && !out_tready);
      unique case (state_r)
        ST_IDLE: begin
          vi_r <= '0;
          if (in_tvalid && in_tuser == ActLoad && ecount_r < EC'(MAX_EDGES))
            ecount_r <= ecount_r + EC'(1);
        end
        ST_CLEAR: begin
          vi_r <= (vi_r == n - VC'(1)) ? '0 : vi_r + VC'(1);
          found_r <= 1'b0;
        end
        ST_SCAN: begin
          // vrd_r holds vertex vi_r-1 from the read issued in the previous cycle
          if (vi_r != '0 && vrd_r[DistBits+1] && !vrd_r[DistBits] &&
              (!found_r || vrd_r[DistBits-1:0] < best_d_r)) begin
            found_r <= 1'b1;
            best_d_r <= vrd_r[DistBits-1:0];
            best_v_r <= VB'(vi_r - VC'(1));
          end
          if (vi_r == n) begin
            vi_r <= '0;
            if (vrd_r[DistBits+1] && !vrd_r[DistBits] &&
                (!found_r || vrd_r[DistBits-1:0] < best_d_r)) begin
              u_r <= VB'(vi_r - VC'(1));
              du_r <= vrd_r[DistBits-1:0];
            end else begin
              u_r <= best_v_r;
              du_r <= best_d_r;
            end
          end else vi_r <= vi_r + VC'(1);
        end
        ST_EDGE: begin
          if (wdone) begin
            vi_r <= '0;
            found_r <= 1'b0;
          end else if (any_hit) begin
            // a self loop relaxes u itself, which never improves
            tgt_r <= hit_a ? VB'(eb) : VB'(ea);
          end
        end
        ST_EMIT: if (!out_full_r || out_tready) begin
          otd_r <= {3'b0, vrd_r[DistBits+1],
                    vrd_r[DistBits+1] ? vrd_r[DistBits-1:0] : {DistBits{1'b0}},
                    SrcBits'(vi_r)};
          otl_r <= (vi_r == n - VC'(1));
          if (vi_r == n - VC'(1)) ecount_r <= '0;
          else vi_r <= vi_r + VC'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_full_r;
  assign out_tdata  = otd_r;
  assign out_tlast  = otl_r;

  `ASSERT_IMPLY(a_ready_idle, clk, rst_n, in_tready, state_r == ST_IDLE)
  `ASSERT_IMPLY(a_ecount_max, clk, rst_n, 1'b1, ecount_r <= EC'(MAX_EDGES))
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
endmodule
`default_nettype wire
